// ===== rtl/hbdc_pkg.sv =====
// Package for the half-band decimator cascade: coefficient tables, FSM type.
// No dependencies.
`default_nettype none
package hbdc_pkg;

  localparam int TableFrac = 17;
  localparam int TableW    = 18;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_RD_A,
    ST_RD_B,
    ST_MAC,
    ST_FINISH,
    ST_OUT
  } state_e;

  typedef enum logic [0:0] {
    REG_FILTER_SELECT = 1'b0,
    REG_STAGE_COUNT   = 1'b1
  } reg_idx_e;

  // Q1.17 table entry, outermost pair first.
  function automatic logic signed [TableW-1:0] coef_lookup(input logic [1:0] sel,
                                                           input logic [4:0] k);
    logic signed [TableW-1:0] c;
    c = '0;
    case (sel)
      2'd0: begin
        case (k)
          5'd0: c = 18'sd292;    5'd1: c = -18'sd513;   5'd2: c = 18'sd816;
          5'd3: c = -18'sd1223;  5'd4: c = 18'sd1766;   5'd5: c = -18'sd2500;
          5'd6: c = 18'sd3527;   5'd7: c = -18'sd5064;  5'd8: c = 18'sd7686;
          5'd9: c = -18'sd13504; 5'd10: c = 18'sd41586;
          default: c = '0;
        endcase
      end
      2'd1: begin
        case (k)
          5'd0: c = -18'sd1774;  5'd1: c = 18'sd2875;   5'd2: c = -18'sd4520;
          5'd3: c = 18'sd7276;   5'd4: c = -18'sd13250; 5'd5: c = 18'sd41500;
          default: c = '0;
        endcase
      end
      2'd2: begin
        case (k)
          5'd0: c = 18'sd11;     5'd1: c = -18'sd25;    5'd2: c = 18'sd46;
          5'd3: c = -18'sd76;    5'd4: c = 18'sd120;    5'd5: c = -18'sd179;
          5'd6: c = 18'sd257;    5'd7: c = -18'sd359;   5'd8: c = 18'sd489;
          5'd9: c = -18'sd653;   5'd10: c = 18'sd858;   5'd11: c = -18'sd1114;
          5'd12: c = 18'sd1433;  5'd13: c = -18'sd1837; 5'd14: c = 18'sd2356;
          5'd15: c = -18'sd3045; 5'd16: c = 18'sd4005;  5'd17: c = -18'sd5457;
          5'd18: c = 18'sd7979;  5'd19: c = -18'sd13685; 5'd20: c = 18'sd41647;
          default: c = '0;
        endcase
      end
      default: begin
        case (k)
          5'd0: c = 18'sd748;    5'd1: c = -18'sd694;   5'd2: c = 18'sd1006;
          5'd3: c = -18'sd1421;  5'd4: c = 18'sd1958;   5'd5: c = -18'sd2684;
          5'd6: c = 18'sd3687;   5'd7: c = -18'sd5201;  5'd8: c = 18'sd7786;
          5'd9: c = -18'sd13569; 5'd10: c = 18'sd41606;
          default: c = '0;
        endcase
      end
    endcase
    return c;
  endfunction

  function automatic logic [4:0] coef_len(input logic [1:0] sel);
    logic [4:0] n;
    case (sel)
      2'd0:    n = 5'd11;
      2'd1:    n = 5'd6;
      2'd2:    n = 5'd21;
      default: n = 5'd11;
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/hbdc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module hbdc_ram #(
  parameter int Width = 24,
  parameter int Depth = 581
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

// ===== rtl/hbdc_mac.sv =====
// Shared pre-add / multiply / accumulate unit with round and saturate.
// Depends on hbdc_pkg.
`default_nettype none
module hbdc_mac #(
  parameter int SampleWidth = 24,
  parameter int CoefWidth   = 18,
  parameter int AccWidth    = 48
) (
  input  wire logic                          clk_i,
  input  wire logic                          clear_i,
  input  wire logic                          mac_i,
  input  wire logic                          center_i,
  input  wire logic signed [SampleWidth-1:0] a_i,
  input  wire logic signed [SampleWidth-1:0] b_i,
  input  wire logic signed [CoefWidth-1:0]   coef_i,
  output logic signed [SampleWidth-1:0]      result_o
);
  import hbdc_pkg::*;

  localparam int F = CoefWidth - 1;

  logic signed [AccWidth-1:0] acc_q, acc_d;
  logic signed [SampleWidth:0] pair;
  logic signed [SampleWidth+CoefWidth:0] prod_n;
  logic signed [AccWidth-1:0] prod;
  logic signed [AccWidth-1:0] rnd;
  logic signed [AccWidth-1:0] shifted;
  logic signed [AccWidth-1:0] hi_lim, lo_lim;

  assign pair   = (SampleWidth+1)'(a_i) + (SampleWidth+1)'(b_i);
  // Pair sum times coefficient at its natural width, then sign-extended.
  assign prod_n = pair * coef_i;
  assign prod   = AccWidth'(prod_n);

  always_comb begin
    acc_d = acc_q;
    if (clear_i) begin
      acc_d = AccWidth'(1) <<< (F - 1);
    end else if (center_i) begin
      acc_d = acc_q + (AccWidth'(a_i) <<< (F - 1));
    end else if (mac_i) begin
      acc_d = acc_q + prod;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  // Result includes the term being added this cycle (center tap).
  assign rnd     = acc_d;
  assign shifted = rnd >>> F;
  assign hi_lim  = (AccWidth'(1) <<< (SampleWidth - 1)) - AccWidth'(1);
  assign lo_lim  = -(AccWidth'(1) <<< (SampleWidth - 1));

  always_comb begin
    if (shifted > hi_lim) begin
      result_o = hi_lim[SampleWidth-1:0];
    end else if (shifted < lo_lim) begin
      result_o = lo_lim[SampleWidth-1:0];
    end else begin
      result_o = shifted[SampleWidth-1:0];
    end
  end
endmodule
`default_nettype wire

// ===== rtl/halfband_decimator_cascade.sv =====
// Top level of the half-band decimator cascade: sequencer, delay RAM, MAC.
// Depends on hbdc_pkg, hbdc_ram, hbdc_mac.
//
//  channel  | dir | handshake        | payload
//  s_axis   | in  | tvalid/tready    | tdata[23:0] sample_in
//  m_axis   | out | tvalid/tready    | tdata[23:0] sample_out
//  cfg      | in  | cfg_we_i         | cfg_idx_i, cfg_data_i
//
// A sample walks the stages one at a time; each filtering stage runs on the single
// MAC as a write, two RAM reads per pair, the last product and the center tap.
// An input absorbed by a stage ends after that stage's write, with no result.
// Delay RAM (MaxStages*(4*Pairs-1) entries) is cleared after reset, one entry a cycle.
// Input is not taken while a result waits on m_axis.
`default_nettype none
module halfband_decimator_cascade #(
  parameter int MAX_STAGES    = 7,
  parameter int MAX_TAP_PAIRS = 21,
  parameter int SAMPLE_WIDTH  = 24,
  parameter int COEF_WIDTH    = 18
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0] s_axis_tdata, // [SW-1:0] sample_in
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   m_axis_tdata,  // [SW-1:0] sample_out
  input  wire logic                           cfg_we_i,
  input  wire logic                           cfg_idx_i,
  input  wire logic [2:0]                     cfg_data_i
);
  import hbdc_pkg::*;

  localparam int BufLen  = 4 * MAX_TAP_PAIRS - 1;
  localparam int Depth   = MAX_STAGES * BufLen;
  localparam int AW      = $clog2(Depth);
  localparam int PW      = $clog2(BufLen);
  localparam int SW      = $clog2(MAX_STAGES + 1);
  localparam int TW      = ((SAMPLE_WIDTH+7)/8)*8;
  localparam int AccW    = 2 * SAMPLE_WIDTH;
  localparam int JW      = 5;

  state_e state_q, state_d;

  logic [1:0]  fsel_q;
  logic [2:0]  scnt_q;
  logic [SW-1:0] nst;

  logic [MAX_STAGES-1:0] phase_q;
  logic [PW-1:0] widx_q [MAX_STAGES];

  logic [SW-1:0] stage_q, stage_d;
  logic [JW-1:0] j_q;
  logic [JW-1:0] jc_q;      // pair index one read behind j_q
  logic [0:0]    lag_q;     // pipeline of read-valid tokens
  logic signed [SAMPLE_WIDTH-1:0] v_q, v_d;
  logic signed [SAMPLE_WIDTH-1:0] a_q;
  logic [TW-1:0] out_q;
  logic          ovalid_q;

  logic          clr_q;
  logic [AW-1:0] clr_addr_q;

  logic [4:0] len, pairs, first;
  logic [AW-1:0] base;
  logic [PW-1:0] wp;
  logic [AW-1:0] raddr, waddr;
  logic          we;
  logic [SAMPLE_WIDTH-1:0] wdata, rdata;
  logic [PW:0]   dsel;
  logic [PW:0]   ridx;

  logic mac_clear, mac_en, mac_center;
  logic signed [COEF_WIDTH-1:0] coef;
  logic signed [SAMPLE_WIDTH-1:0] fres;
  logic [JW-1:0] jc;   // pair index of the product now at the MAC
  logic signed [TableW-1:0] tc;

  assign nst   = (SW'(scnt_q) > SW'(MAX_STAGES)) ? SW'(MAX_STAGES) : SW'(scnt_q);
  assign len   = coef_len(fsel_q);
  assign pairs = (len < 5'(MAX_TAP_PAIRS)) ? len : 5'(MAX_TAP_PAIRS);
  assign first = len - pairs;
  assign base  = AW'(stage_q[SW-1:0] * BufLen);
  assign wp    = widx_q[stage_q[$clog2(MAX_STAGES)-1+((MAX_STAGES==1)?1:0):0]];

  // Read tap d: index (wp - 1 - d) mod BufLen; here wp already advanced.
  always_comb begin
    dsel = '0;
    if (state_q == ST_RD_A) begin
      dsel = (PW+1)'(4 * pairs - 2) - (PW+1)'(2 * j_q);
    end else if (state_q == ST_RD_B) begin
      dsel = (PW+1)'(2 * j_q);
    end else begin
      dsel = (PW+1)'(2 * pairs - 1);
    end
    ridx = (PW+1)'(wp) + (PW+1)'(BufLen - 1) - dsel;
    if (ridx >= (PW+1)'(BufLen)) ridx = ridx - (PW+1)'(BufLen);
  end

  assign raddr = base + AW'(ridx[PW-1:0]);
  assign waddr = clr_q ? clr_addr_q : base + AW'(wp);
  assign we    = clr_q || (state_q == ST_WRITE);
  assign wdata = clr_q ? '0 : v_q;

  hbdc_ram #(.Width(SAMPLE_WIDTH), .Depth(Depth)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  // Coefficient scaled to COEF_WIDTH-1 fraction bits.
  assign jc = jc_q;
  assign tc = coef_lookup(fsel_q, first + jc);
  always_comb begin
    if (COEF_WIDTH - 1 >= TableFrac) begin
      coef = COEF_WIDTH'(tc) <<< (COEF_WIDTH - 1 - TableFrac);
    end else begin
      coef = COEF_WIDTH'((TableW'(tc) + (TableW'(1) <<< (TableFrac - COEF_WIDTH)))
             >>> (TableFrac - COEF_WIDTH + 1));
    end
  end

  hbdc_mac #(.SampleWidth(SAMPLE_WIDTH), .CoefWidth(COEF_WIDTH), .AccWidth(AccW)) u_mac (
    .clk_i, .clear_i(mac_clear), .mac_i(mac_en), .center_i(mac_center),
    .a_i(mac_center ? $signed(rdata) : a_q), .b_i($signed(rdata)),
    .coef_i(coef), .result_o(fres)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) begin
          state_d = (nst == '0) ? ST_OUT : ST_WRITE;
        end
      end
      ST_WRITE: begin
        state_d = phase_q[stage_q] ? ST_IDLE : ST_RD_A;
      end
      ST_RD_A:   state_d = ST_RD_B;
      ST_RD_B:   state_d = (j_q == pairs - 5'd1) ? ST_MAC : ST_RD_A;
      ST_MAC:    state_d = ST_FINISH;
      ST_FINISH: state_d = (stage_q + SW'(1) >= nst) ? ST_OUT : ST_WRITE;
      ST_OUT:    state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Datapath controls. RD_A reads outer tap; RD_B reads inner tap and the
  // registered outer tap arrives, so MAC fires in the cycle after RD_B
  // (the next RD_A, or ST_MAC for the last pair).
  always_comb begin
    mac_clear  = (state_q == ST_WRITE);
    mac_en     = ((state_q == ST_RD_A) || (state_q == ST_MAC)) && lag_q[0];
    mac_center = (state_q == ST_FINISH);
    stage_d    = stage_q;
    v_d        = v_q;
    case (state_q)
      ST_IDLE: begin
        stage_d = '0;
        v_d     = $signed(s_axis_tdata[SAMPLE_WIDTH-1:0]);
      end
      ST_FINISH: begin
        v_d     = fres;
        stage_d = stage_q + SW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      fsel_q     <= 2'd0;
      scnt_q     <= 3'd1;
      phase_q    <= '0;
      for (int s = 0; s < MAX_STAGES; s++) widx_q[s] <= '0;
      stage_q    <= '0;
      j_q        <= '0;
      jc_q       <= '0;
      lag_q      <= '0;
      ovalid_q   <= 1'b0;
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      state_q <= state_d;
      stage_q <= stage_d;
      if (clr_q) begin
        if (clr_addr_q == AW'(Depth - 1)) clr_q <= 1'b0;
        clr_addr_q <= clr_addr_q + AW'(1);
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_FILTER_SELECT) fsel_q <= cfg_data_i[1:0];
        else scnt_q <= cfg_data_i;
      end
      if (state_q == ST_WRITE) begin
        phase_q[stage_q] <= ~phase_q[stage_q];
        widx_q[stage_q]  <= (wp == PW'(BufLen - 1)) ? '0 : wp + PW'(1);
        j_q              <= '0;
        lag_q            <= '0;
      end
      if (state_q == ST_RD_A) lag_q[0] <= 1'b0;
      if (state_q == ST_RD_B) begin
        lag_q[0] <= 1'b1;
        jc_q     <= j_q;
        if (j_q != pairs - 5'd1) j_q <= j_q + JW'(1);
      end
      if (state_q == ST_OUT) ovalid_q <= 1'b1;
      else if (m_axis_tready) ovalid_q <= 1'b0;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE) && !clr_q && !ovalid_q;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = out_q;

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
    if (state_q == ST_RD_A || state_q == ST_MAC) a_q <= a_q;
    if (state_q == ST_RD_B) a_q <= $signed(rdata);
    if (state_q == ST_OUT) out_q <= TW'(v_q[SAMPLE_WIDTH-1:0]);
  end

  // Schedule: RD_A(j) issues outer read; RD_B(j) issues inner read, outer
  // data appears -> a_q; next cycle (RD_A(j+1) or MAC) inner data appears
  // and the MAC adds coef(j)*(a_q+rdata). Coef index must lag by one.
endmodule
`default_nettype wire

// ===== rtl/hbdc_checker.sv =====
// Port-level checker for the half-band decimator cascade, bound to the top.
// Depends on halfband_decimator_cascade.
`default_nettype none
module hbdc_sva (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata
);
  a_no_in_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("input taken with result pending");
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready) else $error("ready after request");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");
endmodule

bind halfband_decimator_cascade hbdc_sva u_hbdc_checker (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata(m_axis_tdata[23:0])
);
`default_nettype wire
